// ===== hw/rtl/ising_lattice_sync_update_unit_defines.svh =====
// Assertion macros for the Ising lattice update unit.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ISING_LATTICE_SYNC_UPDATE_UNIT_DEFINES_SVH
`define ISING_LATTICE_SYNC_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ILSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILSU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ilsu_pkg.sv =====
// Shared types and constants of the Ising lattice update unit.
// No dependencies.
`default_nettype none

package ilsu_pkg;

	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int RAND_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_THR   = 5;
	localparam int THR_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_UPDATE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_NEG4 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEG2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POS2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POS4 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE = 3'd5;

	// one-bit write into a row-wide lattice memory
	typedef struct packed {
		logic en;
		logic spin;
	} ram_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ilsu_row_ram.sv =====
// Row-organised spin memory: bit-granular write, one registered row read.
// Depends on ilsu_pkg for the write control struct.
`default_nettype none

module ilsu_row_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(WIDTH)
) (
	input  wire                  clk,
	input  wire ilsu_pkg::ram_wr_t wr,
	input  wire logic [AW-1:0]   waddr,
	input  wire logic [CW-1:0]   wcol,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   raddr,
	output logic [WIDTH-1:0]     rd_row_q
);
	import ilsu_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[waddr][wcol] <= wr.spin;
		end
		if (rd_en) begin
			rd_row_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ilsu_cfg_regs.sv =====
// Acceptance thresholds and flip gate register file.
// Depends on ilsu_pkg for register indexes.
`default_nettype none

module ilsu_cfg_regs #(
	parameter int PROB_BITS = 16,
	localparam int RW = PROB_BITS + 1
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire logic                                 we,
	input  wire logic [ilsu_pkg::CFG_IDX_W-1:0]       idx,
	input  wire logic [RW-1:0]                        data,
	output logic [ilsu_pkg::NUM_THR-1:0][RW-1:0]      thr_q,
	output logic [RW-1:0]                             gate_q
);
	import ilsu_pkg::*;

	localparam longint unsigned ONE_L = 64'd1 << PROB_BITS;
	localparam logic [RW-1:0] ONE_Q    = {1'b1, {PROB_BITS{1'b0}}};
	localparam logic [RW-1:0] GATE_RST = RW'((ONE_L + 64'd5) / 64'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= {NUM_THR{ONE_Q}};
			gate_q <= GATE_RST;
		end else if (we) begin
			case (idx)
				CFG_NEG4, CFG_NEG2, CFG_ZERO, CFG_POS2, CFG_POS4: begin
					thr_q[idx] <= data;
				end
				CFG_GATE: begin
					gate_q <= data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ising_lattice_sync_update_unit.sv =====
// A result is presented on the output register after stages s1, s2 and s3; loads
// and unused opcodes give none. One transaction per cycle when out_ready does not
// stall, set by the four-stage pipeline and three row-memory copies per bank; after
// a sweep-ending update the input holds until that update's next-bank write lands.
// Reset clears valid bits and bank select and presets configuration; the lattice
// memory is not cleared. Depends on ilsu_pkg, ilsu_cfg_regs, ilsu_row_ram, defines.
`default_nettype none
`include "ising_lattice_sync_update_unit_defines.svh"

module ising_lattice_sync_update_unit #(
	parameter int ROWS      = 64,
	parameter int COLS      = 64,
	parameter int PROB_BITS = 16
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ilsu_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [PROB_BITS:0]                cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        opcode,
	input  wire logic [ilsu_pkg::ROW_W-1:0]        row,
	input  wire logic [ilsu_pkg::COL_W-1:0]        col,
	input  wire logic                              spin_in,
	input  wire logic [ilsu_pkg::RAND_W-1:0]       rand_accept,
	input  wire logic [ilsu_pkg::RAND_W-1:0]       rand_gate,
	input  wire logic                              last_site,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [ilsu_pkg::ROW_W-1:0]             site_row,
	output logic [ilsu_pkg::COL_W-1:0]             site_col,
	output logic                                   spin_out,
	output logic                                   flipped,
	output logic                                   sweep_done
);
	import ilsu_pkg::*;

	localparam int RB = $clog2(ROWS);
	localparam int CB = $clog2(COLS);
	localparam int RW = PROB_BITS + 1;
	localparam int RU = (PROB_BITS < RAND_W) ? PROB_BITS : RAND_W;
	localparam int NCOPY = 3;

	typedef struct packed {
		logic ld;
		logic upd;
		logic rd;
		logic last;
	} ctl_t;

	// configuration
	logic [NUM_THR-1:0][RW-1:0] thr_cfg;
	logic [RW-1:0]              gate_cfg;

	ilsu_cfg_regs #(.PROB_BITS(PROB_BITS)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.thr_q  (thr_cfg),
		.gate_q (gate_cfg)
	);

	// site reduction tables
	logic [ROW_W-1:0] row_tbl [2**ROW_W];
	logic [COL_W-1:0] col_tbl [2**COL_W];

	for (genvar i = 0; i < 2**ROW_W; i++) begin : g_row_tbl
		assign row_tbl[i] = ROW_W'(i % ROWS);
	end
	for (genvar i = 0; i < 2**COL_W; i++) begin : g_col_tbl
		assign col_tbl[i] = COL_W'(i % COLS);
	end

	// handshake and stage control
	logic in_acc;
	logic swap_pend;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic bank_q;

	// front end
	logic [RB-1:0] r_in, up_in, dn_in;
	logic [CB-1:0] c_in, lf_in, rt_in;
	logic [RW-1:0] ra_in, rg_in;
	ctl_t          ctl_in;

	// stage registers
	ctl_t          ctl_s1, ctl_s2, ctl_s3;
	logic          bank_s1, bank_s2, bank_s3;
	logic [RB-1:0] r_s1, up_s1, dn_s1, r_s2, r_s3;
	logic [CB-1:0] c_s1, lf_s1, rt_s1, c_s2, lf_s2, rt_s2, c_s3;
	logic          spin_s1, s_s3;
	logic [RW-1:0] ra_s1, ra_s2, ra_s3, thr_s3;
	logic          gok_s1, gok_s2, gok_s3;
	logic [RB-1:0] r_s4;
	logic [CB-1:0] c_s4;
	logic          spin_s4, flip_s4, done_s4;

	// memory
	logic [COLS-1:0] ram_row [2][NCOPY];
	logic [RB-1:0]   ram_raddr [NCOPY];
	logic [1:0]      ld_we, up_we;
	ram_wr_t         ram_wr [2];
	logic [RB-1:0]   ram_waddr [2];
	logic [CB-1:0]   ram_wcol [2];

	// stage 2 to 3 logic
	logic [COLS-1:0]      row_self, row_up, row_dn;
	logic                 s_bit, u_bit, d_bit, l_bit, t_bit;
	logic [THR_IDX_W-1:0] n_plus, thr_idx;

	// stage 3 to 4 logic
	logic accept_ok, flip_now, new_spin;

	assign rdy_s4 = !vld_s4 || out_ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign swap_pend = (vld_s1 && ctl_s1.upd && ctl_s1.last)
		|| (vld_s2 && ctl_s2.upd && ctl_s2.last)
		|| (vld_s3 && ctl_s3.upd && ctl_s3.last);

	assign in_ready = rdy_s1 && !swap_pend;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		r_in  = RB'(row_tbl[row]);
		c_in  = CB'(col_tbl[col]);
		up_in = (r_in == '0) ? RB'(ROWS - 1) : r_in - 1'b1;
		dn_in = (r_in == RB'(ROWS - 1)) ? '0 : r_in + 1'b1;
		lf_in = (c_in == '0) ? CB'(COLS - 1) : c_in - 1'b1;
		rt_in = (c_in == CB'(COLS - 1)) ? '0 : c_in + 1'b1;
		ra_in = RW'(rand_accept[RU-1:0]);
		rg_in = RW'(rand_gate[RU-1:0]);
		ctl_in.ld   = (opcode == OP_LOAD);
		ctl_in.upd  = (opcode == OP_UPDATE);
		ctl_in.rd   = (opcode == OP_READ);
		ctl_in.last = last_site;
	end

	// valid bits and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			bank_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_acc;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1 && (ctl_s1.upd || ctl_s1.rd);
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (in_acc && ctl_in.upd && ctl_in.last) begin
				bank_q <= !bank_q;
			end
		end
	end

	// payload: stage 1
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ctl_s1  <= ctl_in;
			bank_s1 <= bank_q;
			r_s1    <= r_in;
			up_s1   <= up_in;
			dn_s1   <= dn_in;
			c_s1    <= c_in;
			lf_s1   <= lf_in;
			rt_s1   <= rt_in;
			spin_s1 <= spin_in;
			ra_s1   <= ra_in;
			gok_s1  <= rg_in < gate_cfg;
		end
	end

	// lattice memory: two banks, three row copies each
	assign ram_raddr[0] = r_s1;
	assign ram_raddr[1] = up_s1;
	assign ram_raddr[2] = dn_s1;

	for (genvar b = 0; b < 2; b++) begin : g_bank
		assign ld_we[b] = vld_s1 && rdy_s2 && ctl_s1.ld && (bank_s1 == 1'(b));
		assign up_we[b] = vld_s3 && rdy_s4 && ctl_s3.upd && (bank_s3 != 1'(b));
		assign ram_wr[b].en   = ld_we[b] || up_we[b];
		assign ram_wr[b].spin = ld_we[b] ? spin_s1 : new_spin;
		assign ram_waddr[b]   = ld_we[b] ? r_s1 : r_s3;
		assign ram_wcol[b]    = ld_we[b] ? c_s1 : c_s3;

		for (genvar k = 0; k < NCOPY; k++) begin : g_copy
			ilsu_row_ram #(.DEPTH(ROWS), .WIDTH(COLS)) u_ram (
				.clk      (clk),
				.wr       (ram_wr[b]),
				.waddr    (ram_waddr[b]),
				.wcol     (ram_wcol[b]),
				.rd_en    (rdy_s2),
				.raddr    (ram_raddr[k]),
				.rd_row_q (ram_row[b][k])
			);
		end
	end

	// payload: stage 2
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ctl_s2  <= ctl_s1;
			bank_s2 <= bank_s1;
			r_s2    <= r_s1;
			c_s2    <= c_s1;
			lf_s2   <= lf_s1;
			rt_s2   <= rt_s1;
			ra_s2   <= ra_s1;
			gok_s2  <= gok_s1;
		end
	end

	// neighbour count and threshold pick
	always_comb begin
		row_self = bank_s2 ? ram_row[1][0] : ram_row[0][0];
		row_up   = bank_s2 ? ram_row[1][1] : ram_row[0][1];
		row_dn   = bank_s2 ? ram_row[1][2] : ram_row[0][2];
		s_bit    = row_self[c_s2];
		l_bit    = row_self[lf_s2];
		t_bit    = row_self[rt_s2];
		u_bit    = row_up[c_s2];
		d_bit    = row_dn[c_s2];
		n_plus   = THR_IDX_W'(u_bit) + THR_IDX_W'(d_bit)
			+ THR_IDX_W'(l_bit) + THR_IDX_W'(t_bit);
		thr_idx  = s_bit ? n_plus : THR_IDX_W'(NUM_THR - 1) - n_plus;
	end

	// payload: stage 3
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ctl_s3  <= ctl_s2;
			bank_s3 <= bank_s2;
			r_s3    <= r_s2;
			c_s3    <= c_s2;
			s_s3    <= s_bit;
			ra_s3   <= ra_s2;
			thr_s3  <= thr_cfg[thr_idx];
			gok_s3  <= gok_s2;
		end
	end

	// flip decision; the new spin goes to the other bank
	assign accept_ok = ra_s3 < thr_s3;
	assign flip_now  = ctl_s3.upd && accept_ok && gok_s3;
	assign new_spin  = s_s3 ^ flip_now;

	// payload: stage 4 (output register)
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			r_s4    <= r_s3;
			c_s4    <= c_s3;
			spin_s4 <= new_spin;
			flip_s4 <= flip_now;
			done_s4 <= ctl_s3.upd && ctl_s3.last;
		end
	end

	assign out_valid  = vld_s4;
	assign site_row   = ROW_W'(r_s4);
	assign site_col   = COL_W'(c_s4);
	assign spin_out   = spin_s4;
	assign flipped    = flip_s4;
	assign sweep_done = done_s4;

	`ILSU_ASSERT_IMP(a_bank_epoch, vld_s1 && vld_s3, bank_s1 == bank_s3, "bank mix in pipeline")
	`ILSU_ASSERT_IMP(a_wr_excl, 1'b1, !((ld_we[0] && up_we[0]) || (ld_we[1] && up_we[1])), "write clash")
	`ILSU_ASSERT_NXT(a_swap_hold, in_acc && ctl_in.upd && ctl_in.last, !in_ready, "no hold on swap")

endmodule

`default_nettype wire

// ===== test/ising_lattice_sync_update_unit_test.sv =====
// Self-checking testbench for ising_lattice_sync_update_unit: load, read and
// Metropolis update transactions predicted against an in-bench two-bank lattice.
// Depends on ilsu_pkg and the unit under test; nothing else.
`timescale 1ns / 100ps

module ising_lattice_sync_update_unit_test;

	import ilsu_pkg::*;

	localparam int ROWS      = 64;
	localparam int COLS      = 64;
	localparam int PROB_BITS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WIN_BASE  = 60;
	localparam int WIN_SPAN  = 8;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             spin;
		logic             flipped;
		logic             sweep_done;
	} site_result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx     = '0;
	logic [PROB_BITS:0]   cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [1:0]           opcode      = '0;
	logic [ROW_W-1:0]     row         = '0;
	logic [COL_W-1:0]     col         = '0;
	logic                 spin_in     = 1'b0;
	logic [RAND_W-1:0]    rand_accept = '0;
	logic [RAND_W-1:0]    rand_gate   = '0;
	logic                 last_site   = 1'b0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [ROW_W-1:0]     site_row;
	logic [COL_W-1:0]     site_col;
	logic                 spin_out;
	logic                 flipped;
	logic                 sweep_done;

	bit                   lattice [0:1][0:ROWS-1][0:COLS-1];
	bit                   written [0:1][0:ROWS-1][0:COLS-1];
	bit                   bank_sel = 1'b0;
	logic [PROB_BITS:0]   accept_thr [NUM_THR] = '{default: 17'd65536};
	logic [PROB_BITS:0]   gate_thr = 17'd6554;
	site_result_t         site_expect_q [$];
	int                   mismatch_count = 0;
	int                   burst_left = 0;
	bit                   sender_steady = 1'b0;
	logic [15:0]          ready_tick = '0;
	logic [15:0]          ready_pattern = '1;

	ising_lattice_sync_update_unit #(
		.ROWS(ROWS),
		.COLS(COLS),
		.PROB_BITS(PROB_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.row(row),
		.col(col),
		.spin_in(spin_in),
		.rand_accept(rand_accept),
		.rand_gate(rand_gate),
		.last_site(last_site),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.site_row(site_row),
		.site_col(site_col),
		.spin_out(spin_out),
		.flipped(flipped),
		.sweep_done(sweep_done)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		ready_tick <= ready_tick + 16'd1;
		if (ready_tick[5:0] == 6'd0) begin
			case ($urandom_range(0, 3))
			0: ready_pattern <= '1;
			1: ready_pattern <= 16'($urandom) | 16'h0101;
			2: ready_pattern <= 16'h5555;
			default: ready_pattern <= (16'($urandom) & 16'h7777) | 16'h0101;
			endcase
		end
		out_ready <= ready_pattern[ready_tick[3:0]];
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] site result mismatch on %s: got %0d, expected %0d",
			$time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		site_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (site_expect_q.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = site_expect_q.pop_front();
				if (site_row !== want.row)
					report_mismatch("site_row", site_row, want.row);
				if (site_col !== want.col)
					report_mismatch("site_col", site_col, want.col);
				if (spin_out !== want.spin)
					report_mismatch("spin_out", spin_out, want.spin);
				if (flipped !== want.flipped)
					report_mismatch("flipped", flipped, want.flipped);
				if (sweep_done !== want.sweep_done)
					report_mismatch("sweep_done", sweep_done, want.sweep_done);
			end
		end
	end

	function automatic void apply_site_op(input logic [1:0] op, input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c, input logic s_in, input logic [RAND_W-1:0] ra,
		input logic [RAND_W-1:0] rg, input logic last);
		site_result_t res;
		int up, dn, lf, rt, n, pidx;
		bit s, take;
		res.row = r;
		res.col = c;
		res.spin = 1'b0;
		res.flipped = 1'b0;
		res.sweep_done = 1'b0;
		case (op)
		OP_LOAD: begin
			lattice[bank_sel][r][c] = s_in;
			written[bank_sel][r][c] = 1'b1;
		end
		OP_READ: begin
			res.spin = lattice[bank_sel][r][c];
			site_expect_q.push_back(res);
		end
		OP_UPDATE: begin
			up = (int'(r) + ROWS - 1) % ROWS;
			dn = (int'(r) + 1) % ROWS;
			lf = (int'(c) + COLS - 1) % COLS;
			rt = (int'(c) + 1) % COLS;
			s = lattice[bank_sel][r][c];
			n = int'(lattice[bank_sel][up][c]) + int'(lattice[bank_sel][dn][c])
				+ int'(lattice[bank_sel][r][lf]) + int'(lattice[bank_sel][r][rt]);
			pidx = s ? n : 4 - n;
			take = ({1'b0, ra} < accept_thr[pidx]) && ({1'b0, rg} < gate_thr);
			res.spin = s ^ take;
			res.flipped = take;
			res.sweep_done = last;
			lattice[!bank_sel][r][c] = res.spin;
			written[!bank_sel][r][c] = 1'b1;
			if (last)
				bank_sel = !bank_sel;
			site_expect_q.push_back(res);
		end
		default: ;
		endcase
	endfunction

	// first entry of the current bank, among the site and optionally its four
	// neighbours, that holds no spin yet
	function automatic bit find_gap(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
		input bit with_nbrs, output logic [ROW_W-1:0] gr, output logic [COL_W-1:0] gc);
		logic [ROW_W-1:0] pr [5];
		logic [COL_W-1:0] pc [5];
		int               lim;
		pr = '{r, r - 1'b1, r + 1'b1, r, r};
		pc = '{c, c, c, c - 1'b1, c + 1'b1};
		lim = with_nbrs ? 5 : 1;
		gr = r;
		gc = c;
		for (int i = 0; i < lim; i++) begin
			if (!written[bank_sel][pr[i]][pc[i]]) begin
				gr = pr[i];
				gc = pc[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [RAND_W-1:0] pick_draw(input logic [PROB_BITS:0] thr);
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return (thr > 17'd65535) ? 16'hFFFF : thr[RAND_W-1:0];
		3: return (thr == 0) ? 16'd0 : ((thr > 17'd65536) ? 16'hFFFF : 16'(thr - 17'd1));
		default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_site_op(input logic [1:0] op, input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c, input logic s, input logic [RAND_W-1:0] ra,
		input logic [RAND_W-1:0] rg, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_steady ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		spin_in <= s;
		rand_accept <= ra;
		rand_gate <= rg;
		last_site <= last;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		apply_site_op(op, r, c, s, ra, rg, last);
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (site_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_thresholds(input logic [PROB_BITS:0] neg4, neg2, zero, pos2, pos4,
		input logic [PROB_BITS:0] gate);
		logic [PROB_BITS:0]   vals [6];
		logic [CFG_IDX_W-1:0] regs [6];
		vals = '{neg4, neg2, zero, pos2, pos4, gate};
		regs = '{CFG_NEG4, CFG_NEG2, CFG_ZERO, CFG_POS2, CFG_POS4, CFG_GATE};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			if (regs[i] == CFG_GATE)
				gate_thr = vals[i];
			else
				accept_thr[regs[i]] = vals[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_lattice_fill();
		for (int r = 0; r < WIN_SPAN; r++)
			for (int c = 0; c < WIN_SPAN; c++)
				send_site_op(OP_LOAD, ROW_W'(WIN_BASE + r), COL_W'(WIN_BASE + c),
					1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
	endtask

	task automatic test_full_sweep();
		for (int r = 1; r < WIN_SPAN - 1; r++)
			for (int c = 1; c < WIN_SPAN - 1; c++)
				send_site_op(OP_UPDATE, ROW_W'(WIN_BASE + r), COL_W'(WIN_BASE + c),
					1'($urandom_range(0, 1)),
					pick_draw(accept_thr[$urandom_range(0, NUM_THR - 1)]),
					pick_draw(gate_thr), r == WIN_SPAN - 2 && c == WIN_SPAN - 2);
	endtask

	task automatic test_corner_sites();
		send_site_op(OP_READ, 0, 0, 1'b0, '0, '0, 1'b1);
		send_site_op(OP_READ, 63, 63, 1'b1, '1, '1, 1'b0);
		send_site_op(OP_LOAD, 63, 0, 1'b1, '1, '1, 1'b1);
		send_site_op(OP_READ, 63, 0, 1'b0, '0, '0, 1'b0);
		send_site_op(OP_LOAD, 0, 63, 1'b0, '0, '0, 1'b0);
		send_site_op(OP_UPDATE, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0);
		send_site_op(OP_UPDATE, 63, 63, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
		send_site_op(OP_UPDATE, 0, 63, 1'b0, 16'hFFFF, 16'd6553, 1'b0);
		send_site_op(OP_UPDATE, 63, 0, 1'b0, 16'd0, 16'd6554, 1'b0);
		send_site_op(OP_UNUSED, 5, 9, 1'b1, '1, '1, 1'b1);
		send_site_op(OP_READ, 0, 63, 1'b0, '0, '0, 1'b0);
	endtask

	task automatic test_bank_swap();
		send_site_op(OP_UPDATE, 1, 1, 1'b0, 16'd0, 16'd0, 1'b1);
		send_site_op(OP_READ, 1, 1, 1'b0, '0, '0, 1'b0);
		send_site_op(OP_LOAD, 1, 2, 1'b1, '0, '0, 1'b0);
		send_site_op(OP_UPDATE, 1, 1, 1'b0, 16'd0, 16'd0, 1'b0);
		send_site_op(OP_UPDATE, 1, 1, 1'b1, 16'd40000, 16'd100, 1'b1);
		send_site_op(OP_READ, 1, 2, 1'b0, '0, '0, 1'b0);
	endtask

	task automatic test_neighbour_products();
		logic [ROW_W-1:0]   nbr_r [4];
		logic [COL_W-1:0]   nbr_c [4];
		logic [PROB_BITS:0] thr;
		logic [RAND_W-1:0]  ra;
		nbr_r = '{63, 1, 0, 0};
		nbr_c = '{0, 0, 63, 1};
		settle_block();
		program_thresholds(17'd65536, 17'd49152, 17'd32768, 17'd16384, 17'd0, 17'd65536);
		send_site_op(OP_LOAD, 0, 0, 1'b1, '0, '0, 1'b0);
		for (int i = 0; i < 4; i++)
			send_site_op(OP_LOAD, nbr_r[i], nbr_c[i], 1'b0, '0, '0, 1'b0);
		for (int n = 0; n <= 4; n++) begin
			if (n > 0)
				send_site_op(OP_LOAD, nbr_r[n-1], nbr_c[n-1], 1'b1, '0, '0, 1'b0);
			thr = accept_thr[n];
			if (n % 2 == 1 || thr == 0)
				ra = (thr > 17'd65535) ? 16'hFFFF : thr[RAND_W-1:0];
			else
				ra = 16'(thr - 17'd1);
			send_site_op(OP_UPDATE, 0, 0, 1'b0, ra, 16'hFFFF, 1'b0);
		end
		send_site_op(OP_LOAD, 0, 0, 1'b0, '0, '0, 1'b0);
		send_site_op(OP_UPDATE, 0, 0, 1'b1, 16'hFFFF, 16'd0, 1'b0);
	endtask

	task automatic test_random_sweeps(input int target);
		int               sent, span, roll, row_ofs, col_ofs;
		bit               raster;
		logic [ROW_W-1:0] r, gr;
		logic [COL_W-1:0] c, gc;
		sent = 0;
		while (sent < target) begin
			span = $urandom_range(3, 60);
			raster = ($urandom_range(0, 2) == 0);
			row_ofs = $urandom_range(0, WIN_SPAN - 1);
			col_ofs = $urandom_range(0, WIN_SPAN - 1);
			for (int k = 0; k < span; k++) begin
				if (raster) begin
					col_ofs = col_ofs + 1;
					if (col_ofs == WIN_SPAN) begin
						col_ofs = 0;
						row_ofs = (row_ofs + 1) % WIN_SPAN;
					end
				end else begin
					row_ofs = $urandom_range(0, WIN_SPAN - 1);
					col_ofs = $urandom_range(0, WIN_SPAN - 1);
				end
				r = ROW_W'(WIN_BASE + row_ofs);
				c = COL_W'(WIN_BASE + col_ofs);
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					if (find_gap(r, c, 1'b1, gr, gc))
						send_site_op(OP_LOAD, gr, gc, 1'($urandom_range(0, 1)),
							16'($urandom), 16'($urandom), 1'b0);
					else
						send_site_op(OP_UPDATE, r, c, 1'($urandom_range(0, 1)),
							pick_draw(accept_thr[$urandom_range(0, NUM_THR - 1)]),
							pick_draw(gate_thr), k == span - 1);
					sent++;
				end else if (roll < 84) begin
					if (find_gap(r, c, 1'b0, gr, gc))
						send_site_op(OP_LOAD, gr, gc, 1'($urandom_range(0, 1)),
							16'($urandom), 16'($urandom), 1'b0);
					else
						send_site_op(OP_READ, r, c, 1'($urandom_range(0, 1)),
							16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
					sent++;
				end else if (roll < 97) begin
					send_site_op(OP_LOAD, r, c, 1'($urandom_range(0, 1)), 16'($urandom),
						16'($urandom), 1'($urandom_range(0, 1)));
					sent++;
				end else begin
					send_site_op(OP_UNUSED, r, c, 1'($urandom_range(0, 1)), 16'($urandom),
						16'($urandom), 1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lattice_fill();
		test_full_sweep();
		test_corner_sites();
		test_bank_swap();
		test_neighbour_products();

		settle_block();
		program_thresholds(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd65536);
		test_random_sweeps(250);

		settle_block();
		program_thresholds(17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
		test_random_sweeps(250);

		settle_block();
		program_thresholds(17'd65536, 17'd65536, 17'd65536, 17'd8869, 17'd787, 17'd65535);
		test_random_sweeps(250);

		settle_block();
		program_thresholds(17'd65535, 17'd65535, 17'd65535, 17'd65535, 17'd65535, 17'd0);
		test_random_sweeps(250);

		settle_block();
		program_thresholds(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
			17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
			17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
		test_random_sweeps(250);

		settle_block();
		sender_steady = 1'b1;
		program_thresholds(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
			17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
			17'($urandom_range(0, 65536)), 17'd65536);
		test_random_sweeps(250);
		sender_steady = 1'b0;

		settle_block();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule
